@@ design/mwo_pkg.sv @@
`default_nettype none

package mwo_pkg;

   // Parameter defaults
   localparam int PHASE_BITS_DEF      = 32;
   localparam int SINE_TABLE_BITS_DEF = 10;
   localparam int SAMPLE_BITS_DEF     = 16;

   // Fixed field widths
   localparam int VIEW_BITS   = 32;
   localparam int AMP_BITS    = 15;
   localparam int ROM_BITS    = 15;
   localparam int SAMPLE_W    = 16;
   localparam int INDEX_BITS  = 32;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [31:0] DUTY_RESET = 32'h8000_0000;
   localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   typedef enum logic [2:0] {
      WAVE_SINE     = 3'd0,
      WAVE_SQUARE   = 3'd1,
      WAVE_TRIANGLE = 3'd2,
      WAVE_RISE     = 3'd3,
      WAVE_FALL     = 3'd4,
      WAVE_OFFSET   = 3'd5
   } wave_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WAVE_MODE    = 3'd0,
      CSR_PHASE_STEP   = 3'd1,
      CSR_AMPLITUDE    = 3'd2,
      CSR_DUTY         = 3'd3,
      CSR_OFFSET       = 3'd4,
      CSR_SAMPLE_COUNT = 3'd5
   } csr_type;

   // Right shift applied to amplitude * magnitude
   typedef enum logic [1:0] {
      SCALE_UNIT = 2'd0,
      SCALE_Q15  = 2'd1,
      SCALE_Q30  = 2'd2,
      SCALE_Q31  = 2'd3
   } scale_type;

   typedef struct packed {
      wave_type           wave_mode;
      logic [31:0]        phase_step;
      logic [AMP_BITS-1:0] amplitude;
      logic [31:0]        duty_threshold;
      logic signed [15:0] offset_level;
      logic [31:0]        sample_count;
   } cfg_type;

   typedef struct packed {
      logic                 valid;
      logic                 last;
      logic [VIEW_BITS-1:0] phase;
   } phase_beat_type;

   typedef struct packed {
      logic        valid;
      logic        last;
      logic        neg;
      logic        use_amp;
      scale_type   scale;
      logic [31:0] mag;
   } shape_beat_type;

   // Quarter-wave sine entry k of a table with 2^table_bits steps, unsigned Q0.15,
   // built from a fixed-point Taylor series in Q30.
   function automatic logic [ROM_BITS-1:0] sine_entry(input int unsigned k,
                                                      input int unsigned table_bits);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] e;
      x  = (HALF_PI_Q30 * 64'(k)) >> table_bits;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd156);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd110);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd72);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd42);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd20);
      t  = Q30_ONE - (((x2 * t) >> 30) / 64'd6);
      s  = (x * t) >> 30;
      e  = (s * 64'd32768 + (64'd1 << 29)) >> 30;
      if (e > 64'd32767) begin
         e = 64'd32767;
      end
      return e[ROM_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

@@ design/mwo_phase.sv @@
`default_nettype none

// Phase accumulator and sample counter; takes the input beat.
module mwo_phase #(
   parameter int PHASE_BITS = mwo_pkg::PHASE_BITS_DEF
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_stall,
   input  wire                     req_restart,
   input  wire mwo_pkg::cfg_type   cfg,
   input  wire                     next_go,
   output mwo_pkg::phase_beat_type beat
);

   logic [PHASE_BITS-1:0]          phase_acc_ff, phase_acc_in;
   logic [mwo_pkg::INDEX_BITS-1:0] index_ff, index_in;
   logic                           valid_ff, valid_in;
   logic                           last_ff, last_in;
   logic [mwo_pkg::VIEW_BITS-1:0]  phase_ff, phase_in;

   logic [PHASE_BITS-1:0]          acc_cur;
   logic [PHASE_BITS-1:0]          step_aligned;
   logic [mwo_pkg::VIEW_BITS-1:0]  view;
   logic [mwo_pkg::INDEX_BITS-1:0] index_cur;
   logic [mwo_pkg::INDEX_BITS-1:0] index_inc;
   logic                           take;
   logic                           accept;
   logic                           emit;

   // Slot is free when empty or moving on
   assign take      = !valid_ff || next_go;
   assign req_stall = !take;
   assign accept    = req_valid && take;

   // Restart clears phase and count before this tick
   assign acc_cur   = req_restart ? '0 : phase_acc_ff;
   assign index_cur = req_restart ? '0 : index_ff;
   assign index_inc = index_cur + 32'd1;
   assign emit      = index_cur < cfg.sample_count;

   // Accumulator left-aligned to a 32-bit view (its top 32 bits when wider), step aligned to the same view
   generate
      if (PHASE_BITS >= mwo_pkg::VIEW_BITS) begin : g_wide
         assign view         = acc_cur[PHASE_BITS-1 -: mwo_pkg::VIEW_BITS];
         assign step_aligned = PHASE_BITS'(cfg.phase_step) << (PHASE_BITS - mwo_pkg::VIEW_BITS);
      end else begin : g_narrow
         assign view         = mwo_pkg::VIEW_BITS'(acc_cur) << (mwo_pkg::VIEW_BITS - PHASE_BITS);
         assign step_aligned = PHASE_BITS'(cfg.phase_step >> (mwo_pkg::VIEW_BITS - PHASE_BITS));
      end
   endgenerate

   // Next state
   always_comb begin
      phase_acc_in = phase_acc_ff;
      index_in     = index_ff;
      valid_in     = valid_ff;
      last_in      = last_ff;
      phase_in     = phase_ff;
      if (take) begin
         valid_in = accept && emit;
         last_in  = index_inc == cfg.sample_count;
         phase_in = view;
      end
      if (accept) begin
         phase_acc_in = emit ? acc_cur + step_aligned : acc_cur;
         index_in     = emit ? index_inc : index_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff <= '0;
         index_ff     <= '0;
         valid_ff     <= 1'b0;
      end else begin
         phase_acc_ff <= phase_acc_in;
         index_ff     <= index_in;
         valid_ff     <= valid_in;
      end
      last_ff  <= last_in;
      phase_ff <= phase_in;
   end

   assign beat.valid = valid_ff;
   assign beat.last  = last_ff;
   assign beat.phase = phase_ff;

endmodule

`default_nettype wire

@@ design/mwo_shape.sv @@
`default_nettype none

// Waveform shaping: sine ROM read, magnitude and sign for the scaler.
module mwo_shape #(
   parameter int SINE_TABLE_BITS = mwo_pkg::SINE_TABLE_BITS_DEF
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire mwo_pkg::cfg_type    cfg,
   input  wire mwo_pkg::phase_beat_type in_beat,
   input  wire                      next_go,
   output logic                     go,
   output mwo_pkg::shape_beat_type  out_beat
);

   localparam int TABLE_N = 1 << SINE_TABLE_BITS;
   localparam int ADDR_W  = SINE_TABLE_BITS + 1;

   logic [mwo_pkg::ROM_BITS-1:0] sine_rom [TABLE_N+1];

   logic                         valid_ff, valid_in;
   logic                         last_ff, last_in;
   logic                         neg_ff, neg_in;
   logic                         use_amp_ff, use_amp_in;
   logic                         sine_ff, sine_in;
   mwo_pkg::scale_type           scale_ff, scale_in;
   logic [31:0]                  mag_ff, mag_in;
   logic [mwo_pkg::ROM_BITS-1:0] rom_q_ff;

   logic [31:0]                  p;
   logic [1:0]                   quad;
   logic [29:0]                  frac;
   logic [SINE_TABLE_BITS-1:0]   idx;
   logic [ADDR_W-1:0]            rom_addr;
   logic [31:0]                  saw_mag;
   logic [15:0]                  offset_mag;

   // Constant quarter-wave table
   generate
      for (genvar k = 0; k <= TABLE_N; k++) begin : g_rom
         assign sine_rom[k] = mwo_pkg::sine_entry(k, SINE_TABLE_BITS);
      end
   endgenerate

   assign go = !valid_ff || next_go;

   assign p    = in_beat.phase;
   assign quad = p[31:30];
   assign frac = p[29:0];
   assign idx  = p[29 -: SINE_TABLE_BITS];

   // Odd quadrants read the table backwards
   assign rom_addr = quad[0] ? ADDR_W'(TABLE_N) - {1'b0, idx} : {1'b0, idx};

   // Distance of the phase from one half cycle
   assign saw_mag    = p[31] ? {1'b0, p[30:0]} : 32'h8000_0000 - p;
   assign offset_mag = cfg.offset_level[15] ? 16'(-cfg.offset_level) : cfg.offset_level;

   // Per-mode magnitude, sign and scale
   always_comb begin
      mag_in     = 32'd0;
      neg_in     = 1'b0;
      use_amp_in = 1'b1;
      sine_in    = 1'b0;
      scale_in   = mwo_pkg::SCALE_UNIT;
      case (cfg.wave_mode)
         mwo_pkg::WAVE_SINE: begin
            sine_in  = 1'b1;
            neg_in   = quad[1];
            scale_in = mwo_pkg::SCALE_Q15;
         end
         mwo_pkg::WAVE_SQUARE: begin
            mag_in = 32'd1;
            neg_in = !(p < cfg.duty_threshold);
         end
         mwo_pkg::WAVE_TRIANGLE: begin
            mag_in   = quad[0] ? 32'h4000_0000 - {2'b00, frac} : {2'b00, frac};
            neg_in   = quad[1];
            scale_in = mwo_pkg::SCALE_Q30;
         end
         mwo_pkg::WAVE_RISE: begin
            mag_in   = saw_mag;
            neg_in   = !p[31];
            scale_in = mwo_pkg::SCALE_Q31;
         end
         mwo_pkg::WAVE_FALL: begin
            mag_in   = saw_mag;
            neg_in   = p[31];
            scale_in = mwo_pkg::SCALE_Q31;
         end
         mwo_pkg::WAVE_OFFSET: begin
            mag_in     = 32'(offset_mag);
            neg_in     = cfg.offset_level[15];
            use_amp_in = 1'b0;
         end
         default: begin
            use_amp_in = 1'b0;
         end
      endcase
      last_in  = in_beat.last;
      valid_in = in_beat.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (go) begin
         valid_ff <= valid_in;
      end
      if (go) begin
         last_ff    <= last_in;
         neg_ff     <= neg_in;
         use_amp_ff <= use_amp_in;
         sine_ff    <= sine_in;
         scale_ff   <= scale_in;
         mag_ff     <= mag_in;
         rom_q_ff   <= sine_rom[rom_addr];
      end
   end

   assign out_beat.valid   = valid_ff;
   assign out_beat.last    = last_ff;
   assign out_beat.neg     = neg_ff;
   assign out_beat.use_amp = use_amp_ff;
   assign out_beat.scale   = scale_ff;
   assign out_beat.mag     = sine_ff ? 32'(rom_q_ff) : mag_ff;

endmodule

`default_nettype wire

@@ design/mwo_scale.sv @@
`default_nettype none

// Amplitude multiply, truncation toward zero, saturation, result register.
module mwo_scale #(
   parameter int SAMPLE_BITS = mwo_pkg::SAMPLE_BITS_DEF
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire [mwo_pkg::AMP_BITS-1:0]    amplitude,
   input  wire mwo_pkg::shape_beat_type   in_beat,
   output logic                           go,
   output logic                           rsp_valid,
   input  wire                            rsp_stall,
   output logic signed [mwo_pkg::SAMPLE_W-1:0] rsp_sample,
   output logic                           rsp_last
);

   localparam int PROD_W = mwo_pkg::AMP_BITS + 32;
   localparam logic signed [17:0] SAT_HI = 18'sd2 ** (SAMPLE_BITS - 1) - 18'sd1;
   localparam logic signed [17:0] SAT_LO = -(18'sd2 ** (SAMPLE_BITS - 1));

   logic                                 valid_ff;
   logic                                 last_ff, last_in;
   logic signed [mwo_pkg::SAMPLE_W-1:0]  sample_ff, sample_in;

   logic [mwo_pkg::AMP_BITS-1:0] mult_a;
   logic [PROD_W-1:0]            product;
   logic [PROD_W-1:0]            shifted;
   logic [16:0]                  mag;
   logic signed [17:0]           value;
   logic signed [17:0]           value_sat;

   assign go = !valid_ff || !rsp_stall;

   // Magnitude times amplitude, shifted down: truncates toward zero
   assign mult_a  = in_beat.use_amp ? amplitude : mwo_pkg::AMP_BITS'(1);
   assign product = PROD_W'(mult_a) * PROD_W'(in_beat.mag);

   always_comb begin
      case (in_beat.scale)
         mwo_pkg::SCALE_UNIT: shifted = product;
         mwo_pkg::SCALE_Q15:  shifted = product >> 15;
         mwo_pkg::SCALE_Q30:  shifted = product >> 30;
         mwo_pkg::SCALE_Q31:  shifted = product >> 31;
         default:             shifted = product;
      endcase
   end

   // Sign and clamp to the sample range
   assign mag   = shifted[16:0];
   assign value = in_beat.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

   always_comb begin
      value_sat = value;
      if (value > SAT_HI) begin
         value_sat = SAT_HI;
      end else if (value < SAT_LO) begin
         value_sat = SAT_LO;
      end
      sample_in = value_sat[mwo_pkg::SAMPLE_W-1:0];
      last_in   = in_beat.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (go) begin
         valid_ff <= in_beat.valid;
      end
      if (go) begin
         sample_ff <= sample_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_sample = sample_ff;
   assign rsp_last   = last_ff;

endmodule

`default_nettype wire

@@ design/multi_waveform_oscillator.sv @@
// Channel | Direction | Beat contents             | Flow control
// req     | in        | restart                   | req_valid / req_stall
// rsp     | out       | sample (s16), last        | rsp_valid / rsp_stall
// csr     | in        | index (3b), data (32b)    | csr_valid / csr_ready (always 1)
//
// One tick a cycle sustained while rsp_stall is low; each taken tick passes the phase
// register, the sine ROM read register, then the multiply into the result register.
// Ticks after the tone ends are taken and give no sample.
// Synchronous active-high reset clears phase, count, pipeline valids and the
// registers to their defaults. A stalled result holds its stage; earlier
// stages keep filling until each is occupied.
`default_nettype none

module multi_waveform_oscillator #(
   parameter int PHASE_BITS      = mwo_pkg::PHASE_BITS_DEF,
   parameter int SINE_TABLE_BITS = mwo_pkg::SINE_TABLE_BITS_DEF,
   parameter int SAMPLE_BITS     = mwo_pkg::SAMPLE_BITS_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_stall,
   input  wire                                req_restart,
   output logic                               rsp_valid,
   input  wire                                rsp_stall,
   output logic signed [mwo_pkg::SAMPLE_W-1:0] rsp_sample,
   output logic                               rsp_last,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire [mwo_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire [mwo_pkg::CSR_DATA_W-1:0]      csr_data
);

   mwo_pkg::cfg_type        cfg_ff, cfg_in;
   mwo_pkg::phase_beat_type phase_beat;
   mwo_pkg::shape_beat_type shape_beat;
   logic                    shape_go;
   logic                    scale_go;

   // Register file
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (mwo_pkg::csr_type'(csr_index))
            mwo_pkg::CSR_WAVE_MODE:    cfg_in.wave_mode      = mwo_pkg::wave_type'(csr_data[2:0]);
            mwo_pkg::CSR_PHASE_STEP:   cfg_in.phase_step     = csr_data;
            mwo_pkg::CSR_AMPLITUDE:    cfg_in.amplitude      = csr_data[mwo_pkg::AMP_BITS-1:0];
            mwo_pkg::CSR_DUTY:         cfg_in.duty_threshold = csr_data;
            mwo_pkg::CSR_OFFSET:       cfg_in.offset_level   = $signed(csr_data[15:0]);
            mwo_pkg::CSR_SAMPLE_COUNT: cfg_in.sample_count   = csr_data;
            default:                   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wave_mode      <= mwo_pkg::WAVE_SINE;
         cfg_ff.phase_step     <= '0;
         cfg_ff.amplitude      <= '0;
         cfg_ff.duty_threshold <= mwo_pkg::DUTY_RESET;
         cfg_ff.offset_level   <= '0;
         cfg_ff.sample_count   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mwo_phase #(
      .PHASE_BITS(PHASE_BITS)
   ) u_phase (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_restart(req_restart),
      .cfg        (cfg_ff),
      .next_go    (shape_go),
      .beat       (phase_beat)
   );

   mwo_shape #(
      .SINE_TABLE_BITS(SINE_TABLE_BITS)
   ) u_shape (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .in_beat (phase_beat),
      .next_go (scale_go),
      .go      (shape_go),
      .out_beat(shape_beat)
   );

   mwo_scale #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_scale (
      .clock     (clock),
      .reset     (reset),
      .amplitude (cfg_ff.amplitude),
      .in_beat   (shape_beat),
      .go        (scale_go),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_sample(rsp_sample),
      .rsp_last  (rsp_last)
   );

endmodule

`default_nettype wire

@@ design/mwo_checker.sv @@
`default_nettype none

module mwo_checker #(
   parameter int SAMPLE_BITS = mwo_pkg::SAMPLE_BITS_DEF
) (
   input wire                                 clock,
   input wire                                 reset,
   input wire                                 req_valid,
   input wire                                 req_stall,
   input wire                                 rsp_valid,
   input wire                                 rsp_stall,
   input wire signed [mwo_pkg::SAMPLE_W-1:0]  rsp_sample,
   input wire                                 rsp_last
);

   localparam logic signed [17:0] SAT_HI = 18'sd2 ** (SAMPLE_BITS - 1) - 18'sd1;
   localparam logic signed [17:0] SAT_LO = -(18'sd2 ** (SAMPLE_BITS - 1));

   // A stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sample) && $stable(rsp_last))
      else $error("stalled result beat changed");

   // Reset empties the pipeline
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat present right after reset");

   // Samples stay inside the configured sample width
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 18'(rsp_sample) <= SAT_HI && 18'(rsp_sample) >= SAT_LO)
      else $error("sample outside the sample width");

   // A tick offered while the result register is empty is never held off
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !rsp_valid |-> !req_stall)
      else $error("tick stalled with an empty result register");

endmodule

bind multi_waveform_oscillator mwo_checker #(
   .SAMPLE_BITS(SAMPLE_BITS)
) u_mwo_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_sample(rsp_sample),
   .rsp_last  (rsp_last)
);

`default_nettype wire
